// File: design/wsup_pkg.sv
package wsup_pkg;

	typedef logic [2:0] status_t;

	localparam status_t ST_OK        = 3'd0;
	localparam status_t ST_NEED_MORE = 3'd1;
	localparam status_t ST_BAD       = 3'd2;
	localparam status_t ST_NOT_UPG   = 3'd3;
	localparam status_t ST_NO_KEY    = 3'd4;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_THREE = 8'h33;

	localparam logic [23:0] CRLFCR = 24'h0D0A0D;

	localparam int NUM_HDR = 5;

	localparam logic [7*8-1:0]  NAME_UPG   = "upgrade";
	localparam logic [10*8-1:0] NAME_CONN  = "connection";
	localparam logic [17*8-1:0] NAME_KEY   = "sec-websocket-key";
	localparam logic [21*8-1:0] NAME_VER   = "sec-websocket-version";
	localparam logic [22*8-1:0] NAME_PROTO = "sec-websocket-protocol";
	localparam logic [9*8-1:0]  WORD_WS    = "websocket";
	localparam logic [7*8-1:0]  WORD_UP    = "upgrade";
	localparam logic [5*8-1:0]  HTTP_PFX   = "HTTP/";

	localparam logic [3:0] WS_LEN = 4'd9;
	localparam logic [3:0] UP_LEN = 4'd7;

	typedef struct packed {
		status_t     status;
		logic [15:0] consumed_bytes;
		logic        consumed_saturated;
		logic        protocol_present;
	} result_t;

	function automatic logic [7:0] lower_byte(input logic [7:0] b);
		logic [7:0] r;
		r = b;
		if (b >= 8'h41 && b <= 8'h5A) begin
			r = b + 8'd32;
		end
		return r;
	endfunction

	function automatic logic [4:0] hdr_len(input logic [2:0] idx);
		logic [4:0] r;
		unique case (idx)
			3'd0: r = 5'd7;
			3'd1: r = 5'd10;
			3'd2: r = 5'd17;
			3'd3: r = 5'd21;
			3'd4: r = 5'd22;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

	// true when byte c is the name's character at position pos
	function automatic logic hdr_hit(input logic [2:0] idx, input logic [4:0] pos,
			input logic [7:0] c);
		int j;
		logic [7:0] ch;
		j = int'(hdr_len(idx)) - 1 - int'(pos);
		ch = 8'h00;
		if (j >= 0) begin
			unique case (idx)
				3'd0: ch = NAME_UPG[j*8 +: 8];
				3'd1: ch = NAME_CONN[j*8 +: 8];
				3'd2: ch = NAME_KEY[j*8 +: 8];
				3'd3: ch = NAME_VER[j*8 +: 8];
				3'd4: ch = NAME_PROTO[j*8 +: 8];
				default: ch = 8'h00;
			endcase
		end
		return (j >= 0) && (c == ch);
	endfunction

	function automatic logic [7:0] ws_char(input logic [3:0] p);
		int j;
		j = 8 - int'(p);
		return (j >= 0) ? WORD_WS[j*8 +: 8] : 8'h00;
	endfunction

	function automatic logic [7:0] up_char(input logic [3:0] p);
		int j;
		j = 6 - int'(p);
		return (j >= 0) ? WORD_UP[j*8 +: 8] : 8'h00;
	endfunction

	function automatic logic [7:0] http_char(input logic [2:0] p);
		int j;
		j = 4 - int'(p);
		return (j >= 0) ? HTTP_PFX[j*8 +: 8] : 8'h00;
	endfunction

endpackage

// File: design/wsup_core.sv
module wsup_core
	import wsup_pkg::*;
#(
	parameter int COUNT_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data_byte,
	input  logic       end_of_buffer,
	output logic       res_valid,
	output result_t    res
);

	typedef enum logic [1:0] {PH_REQ, PH_NAME, PH_VALUE, PH_SKIP} phase_t;
	typedef enum logic [2:0] {K_NONE, K_UPGRADE, K_CONNECTION, K_KEY, K_VERSION,
		K_PROTOCOL} kind_t;

	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	phase_t                phase_q, phase_d;
	logic [23:0]           recent_q, recent_d;
	logic [COUNT_BITS-1:0] count_q, count_d;
	logic [2:0]            tokens_q, tokens_d;
	logic                  in_token_q, in_token_d;
	logic [2:0]            ver_q, ver_d;
	logic [1:0]            line_len_q, line_len_d;
	logic [4:0]            live_q, live_d;
	logic [4:0]            pos_q, pos_d;
	logic                  started_q, started_d;
	logic                  trailing_q, trailing_d;
	kind_t                 kind_q, kind_d;
	logic [3:0]            prog_q, prog_d;
	logic                  nonempty_q, nonempty_d;
	logic                  bad_q, bad_d;
	logic                  ws_q, ws_d;
	logic                  conn_q, conn_d;
	logic                  key_q, key_d;
	logic                  vok_q, vok_d;
	logic                  proto_q, proto_d;

	logic       term;
	logic [7:0] c;
	logic       is_trim, is_blank, is_req_sp;
	logic [31:0] cnt_ext;
	status_t    st;

	assign c         = lower_byte(data_byte);
	assign is_blank  = (data_byte == CH_SP) || (data_byte == CH_TAB);
	assign is_trim   = is_blank || (data_byte == CH_CR);
	assign is_req_sp = is_trim || (data_byte == CH_VT) || (data_byte == CH_FF);
	assign term      = (recent_q == CRLFCR) && (data_byte == CH_LF);
	assign count_d   = (count_q != CNT_MAX) ? count_q + 1'b1 : count_q;
	assign cnt_ext   = 32'(count_d);

	always_comb begin
		if (bad_q) begin
			st = ST_BAD;
		end else if (!ws_q || !conn_q || !vok_q) begin
			st = ST_NOT_UPG;
		end else if (!key_q) begin
			st = ST_NO_KEY;
		end else begin
			st = ST_OK;
		end
	end

	assign res_valid = term || end_of_buffer;

	always_comb begin
		if (term) begin
			res.status             = st;
			res.consumed_bytes     = cnt_ext[15:0];
			res.consumed_saturated = (count_d == CNT_MAX);
			res.protocol_present   = proto_q;
		end else begin
			res.status             = ST_NEED_MORE;
			res.consumed_bytes     = '0;
			res.consumed_saturated = 1'b0;
			res.protocol_present   = 1'b0;
		end
	end

	// per-byte parse step; the terminator is handled in the clocked block
	always_comb begin
		phase_d    = phase_q;
		recent_d   = {recent_q[15:0], data_byte};
		tokens_d   = tokens_q;
		in_token_d = in_token_q;
		ver_d      = ver_q;
		line_len_d = line_len_q;
		live_d     = live_q;
		pos_d      = pos_q;
		started_d  = started_q;
		trailing_d = trailing_q;
		kind_d     = kind_q;
		prog_d     = prog_q;
		nonempty_d = nonempty_q;
		bad_d      = bad_q;
		ws_d       = ws_q;
		conn_d     = conn_q;
		key_d      = key_q;
		vok_d      = vok_q;
		proto_d    = proto_q;

		unique case (phase_q) inside
			PH_REQ: begin
				if (data_byte == CH_LF) begin
					if (tokens_q < 3'd3 || ver_q != 3'd5) begin
						bad_d   = 1'b1;
						phase_d = PH_SKIP;
					end else begin
						phase_d    = PH_NAME;
						line_len_d = '0;
						live_d     = '1;
						pos_d      = '0;
						started_d  = 1'b0;
						trailing_d = 1'b0;
						kind_d     = K_NONE;
						prog_d     = '0;
						nonempty_d = 1'b0;
					end
				end else if (is_req_sp) begin
					in_token_d = 1'b0;
				end else begin
					if (!in_token_q) begin
						in_token_d = 1'b1;
						if (tokens_q < 3'd4) begin
							tokens_d = tokens_q + 3'd1;
						end
					end
					if (tokens_d == 3'd3 && ver_q < 3'd5) begin
						ver_d = (data_byte == http_char(ver_q)) ? ver_q + 3'd1 : 3'd6;
					end
				end
			end
			PH_NAME, PH_VALUE: begin
				if (data_byte == CH_LF) begin
					if (phase_q == PH_VALUE || line_len_q == 2'd0 ||
							(line_len_q == 2'd1 && recent_q[7:0] == CH_CR)) begin
						if (phase_q == PH_VALUE) begin
							case (kind_q)
								K_UPGRADE: if (prog_q == WS_LEN) ws_d = 1'b1;
								K_CONNECTION: if (prog_q == UP_LEN) conn_d = 1'b1;
								K_KEY: key_d = nonempty_q;
								K_VERSION: vok_d = (prog_q == 4'd2) || (prog_q == 4'd3);
								K_PROTOCOL: proto_d = nonempty_q;
								default: ;
							endcase
						end
						phase_d    = PH_NAME;
						line_len_d = '0;
						live_d     = '1;
						pos_d      = '0;
						started_d  = 1'b0;
						trailing_d = 1'b0;
						kind_d     = K_NONE;
						prog_d     = '0;
						nonempty_d = 1'b0;
					end else begin
						bad_d   = 1'b1;
						phase_d = PH_SKIP;
					end
				end else begin
					if (line_len_q < 2'd2) begin
						line_len_d = line_len_q + 2'd1;
					end
					if (phase_q == PH_VALUE) begin
						if (!is_trim) begin
							nonempty_d = 1'b1;
						end
						case (kind_q)
							K_UPGRADE: begin
								if (prog_q < WS_LEN) begin
									if (c == ws_char(prog_q)) prog_d = prog_q + 4'd1;
									else prog_d = (c == ws_char(4'd0)) ? 4'd1 : 4'd0;
								end
							end
							K_CONNECTION: begin
								if (prog_q < UP_LEN) begin
									if (c == up_char(prog_q)) prog_d = prog_q + 4'd1;
									else prog_d = (c == up_char(4'd0)) ? 4'd1 : 4'd0;
								end
							end
							K_VERSION: begin
								// leading blanks, '1', '3', trailing blanks, fail
								case (prog_q) inside
									4'd0: begin
										if (data_byte == CH_ONE) prog_d = 4'd1;
										else if (!is_blank) prog_d = 4'd4;
									end
									4'd1: prog_d = (data_byte == CH_THREE) ? 4'd2 : 4'd4;
									4'd2, 4'd3: prog_d = is_trim ? 4'd3 : 4'd4;
									default: ;
								endcase
							end
							default: ;
						endcase
					end else if (data_byte == CH_COLON) begin
						kind_d = K_NONE;
						for (int i = 0; i < NUM_HDR; i++) begin
							if (live_q[i] && pos_q == hdr_len(3'(i))) begin
								kind_d = kind_t'(3'(i + 1));
							end
						end
						phase_d    = PH_VALUE;
						prog_d     = '0;
						nonempty_d = 1'b0;
					end else if (started_q || !is_blank) begin
						started_d = 1'b1;
						if (is_trim) begin
							trailing_d = 1'b1;
						end else if (trailing_q) begin
							live_d = '0;
						end else begin
							for (int i = 0; i < NUM_HDR; i++) begin
								if (!hdr_hit(3'(i), pos_q, c)) begin
									live_d[i] = 1'b0;
								end
							end
							if (pos_q < 5'd31) begin
								pos_d = pos_q + 5'd1;
							end
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_REQ;
			recent_q   <= '0;
			count_q    <= '0;
			tokens_q   <= '0;
			in_token_q <= 1'b0;
			ver_q      <= '0;
			line_len_q <= '0;
			live_q     <= '1;
			pos_q      <= '0;
			started_q  <= 1'b0;
			trailing_q <= 1'b0;
			kind_q     <= K_NONE;
			prog_q     <= '0;
			nonempty_q <= 1'b0;
			bad_q      <= 1'b0;
			ws_q       <= 1'b0;
			conn_q     <= 1'b0;
			key_q      <= 1'b0;
			vok_q      <= 1'b0;
			proto_q    <= 1'b0;
		end else if (step && term) begin
			// request finished, start the next one from scratch
			phase_q    <= PH_REQ;
			recent_q   <= '0;
			count_q    <= '0;
			tokens_q   <= '0;
			in_token_q <= 1'b0;
			ver_q      <= '0;
			line_len_q <= '0;
			live_q     <= '1;
			pos_q      <= '0;
			started_q  <= 1'b0;
			trailing_q <= 1'b0;
			kind_q     <= K_NONE;
			prog_q     <= '0;
			nonempty_q <= 1'b0;
			bad_q      <= 1'b0;
			ws_q       <= 1'b0;
			conn_q     <= 1'b0;
			key_q      <= 1'b0;
			vok_q      <= 1'b0;
			proto_q    <= 1'b0;
		end else if (step) begin
			phase_q    <= phase_d;
			recent_q   <= recent_d;
			count_q    <= count_d;
			tokens_q   <= tokens_d;
			in_token_q <= in_token_d;
			ver_q      <= ver_d;
			line_len_q <= line_len_d;
			live_q     <= live_d;
			pos_q      <= pos_d;
			started_q  <= started_d;
			trailing_q <= trailing_d;
			kind_q     <= kind_d;
			prog_q     <= prog_d;
			nonempty_q <= nonempty_d;
			bad_q      <= bad_d;
			ws_q       <= ws_d;
			conn_q     <= conn_d;
			key_q      <= key_d;
			vok_q      <= vok_d;
			proto_q    <= proto_d;
		end
	end

endmodule

// File: design/wsup_out_reg.sv
module wsup_out_reg
	import wsup_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  result_t     res,
	output logic        free,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [15:0] consumed_bytes,
	output logic        consumed_saturated,
	output logic        protocol_present
);

	logic    valid_q;
	result_t res_q;

	assign free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign out_valid          = valid_q;
	assign status             = res_q.status;
	assign consumed_bytes     = res_q.consumed_bytes;
	assign consumed_saturated = res_q.consumed_saturated;
	assign protocol_present   = res_q.protocol_present;

endmodule

// File: design/websocket_upgrade_request_parser.sv
// channel  | handshake            | payload
// ---------+----------------------+---------------------------------------------
// in       | in_valid / in_ready  | data_byte, end_of_buffer
// out      | out_valid / out_ready| status, consumed_bytes, consumed_saturated,
//          |                      | protocol_present
//
// one byte per cycle unless a result waits on a full result register; a result reaches the output
// through the input register, then the parse step into the result register
// reset returns the parser to the request line with all counts and flags clear
// a byte that makes no result never waits; one that does waits only while the
// result register is full and not being drained
module websocket_upgrade_request_parser
	import wsup_pkg::*;
#(
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_buffer,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [15:0] consumed_bytes,
	output logic        consumed_saturated,
	output logic        protocol_present
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eob_s1;
	logic       res_valid;
	result_t    res;
	logic       out_free;
	logic       advance;

	assign advance  = valid_s1 && (!res_valid || out_free);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			eob_s1  <= end_of_buffer;
		end
	end

	wsup_core #(
		.COUNT_BITS(COUNT_BITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.data_byte    (byte_s1),
		.end_of_buffer(eob_s1),
		.res_valid    (res_valid),
		.res          (res)
	);

	wsup_out_reg u_out (
		.clk               (clk),
		.arst_n            (arst_n),
		.load              (advance && res_valid),
		.res               (res),
		.free              (out_free),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.status            (status),
		.consumed_bytes    (consumed_bytes),
		.consumed_saturated(consumed_saturated),
		.protocol_present  (protocol_present)
	);

endmodule

// File: tb/tb_websocket_upgrade_request_parser.sv
`timescale 1ns / 100ps

module tb_websocket_upgrade_request_parser
	import wsup_pkg::*;
();

	localparam int STALL_LIMIT = 2000;
	localparam int IDLE_PCT = 28;
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;
	localparam int DIRECTED_LEN = 25;

	typedef enum logic [1:0] {PH_REQLINE, PH_NAME, PH_VALUE, PH_SKIP} phase_e;
	typedef enum logic [2:0] {
		HK_NONE, HK_UPGRADE, HK_CONNECTION, HK_KEY, HK_VERSION, HK_PROTOCOL
	} hkind_e;
	typedef enum logic [2:0] {VER_LEAD, VER_ONE, VER_THIRTEEN, VER_TRAIL, VER_FAIL} ver_e;
	typedef enum int {
		LN_UPGRADE, LN_CONNECTION, LN_KEY, LN_VERSION, LN_PROTOCOL,
		LN_OTHER, LN_NO_COLON, LN_BLANK
	} line_e;

	typedef struct packed {
		logic [7:0] ch;
		logic       eob;
		logic       typed;
		logic       gives;
		result_t    res;
	} drive_row_t;

	localparam result_t NONE_R = '0;
	localparam result_t NEED_R = '{ST_NEED_MORE, 16'd0, 1'b0, 1'b0};

	// short broken requests with known outcome, then a minimal request left to the model
	localparam drive_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
		'{8'h47, 1'b1, 1'b1, 1'b1, NEED_R},
		'{CH_CR, 1'b0, 1'b1, 1'b0, NONE_R},
		'{CH_LF, 1'b0, 1'b1, 1'b0, NONE_R},
		'{CH_CR, 1'b0, 1'b1, 1'b0, NONE_R},
		'{CH_LF, 1'b1, 1'b1, 1'b1, '{ST_BAD, 16'd5, 1'b0, 1'b0}},
		'{8'hFF, 1'b1, 1'b1, 1'b1, NEED_R},
		'{8'h00, 1'b0, 1'b1, 1'b0, NONE_R},
		'{CH_LF, 1'b0, 1'b1, 1'b0, NONE_R},
		'{CH_CR, 1'b0, 1'b1, 1'b0, NONE_R},
		'{CH_LF, 1'b0, 1'b1, 1'b0, NONE_R},
		'{CH_CR, 1'b0, 1'b1, 1'b0, NONE_R},
		'{CH_LF, 1'b1, 1'b1, 1'b1, '{ST_BAD, 16'd7, 1'b0, 1'b0}},
		'{"a",    1'b0, 1'b0, 1'b0, NONE_R},
		'{CH_SP,  1'b0, 1'b0, 1'b0, NONE_R},
		'{"b",    1'b0, 1'b0, 1'b0, NONE_R},
		'{CH_TAB, 1'b0, 1'b0, 1'b0, NONE_R},
		'{"H",    1'b0, 1'b0, 1'b0, NONE_R},
		'{"T",    1'b0, 1'b0, 1'b0, NONE_R},
		'{"T",    1'b0, 1'b0, 1'b0, NONE_R},
		'{"P",    1'b1, 1'b0, 1'b0, NONE_R},
		'{"/",    1'b0, 1'b0, 1'b0, NONE_R},
		'{CH_CR,  1'b0, 1'b0, 1'b0, NONE_R},
		'{CH_LF,  1'b0, 1'b0, 1'b0, NONE_R},
		'{CH_CR,  1'b0, 1'b0, 1'b0, NONE_R},
		'{CH_LF,  1'b0, 1'b0, 1'b0, NONE_R}
	};

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        end_of_buffer = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  status;
	logic [15:0] consumed_bytes;
	logic        consumed_saturated;
	logic        protocol_present;

	websocket_upgrade_request_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.end_of_buffer(end_of_buffer),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.consumed_bytes(consumed_bytes),
		.consumed_saturated(consumed_saturated),
		.protocol_present(protocol_present)
	);

	result_t     expected_results[$];
	logic [7:0]  msg[$];
	int          mismatches = 0;
	int          bytes_sent = 0;
	int unsigned quiet_cycles = 0;
	bit          calm = 1'b0;

	// parser state as the block should hold it
	phase_e      req_phase;
	logic [23:0] last_three;
	logic [15:0] seen_bytes;
	int          tok_count;
	bit          in_tok;
	int          pfx_len;
	int          line_len;
	logic [4:0]  name_live;
	int          name_pos;
	bit          name_begun;
	bit          name_tail;
	hkind_e      val_kind;
	int          word_prog;
	ver_e        ver_state;
	bit          val_nonblank;
	bit          f_bad, f_ws, f_conn, f_key, f_ver, f_proto;

	string http_pfx = "HTTP/";
	string ws_word = "websocket";
	string up_word = "upgrade";

	function string hdr_name(input int i);
		case (i)
			0: return "upgrade";
			1: return "connection";
			2: return "sec-websocket-key";
			3: return "sec-websocket-version";
			default: return "sec-websocket-protocol";
		endcase
	endfunction

	function logic [7:0] to_lower(input logic [7:0] b);
		return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
	endfunction

	function bit is_blank(input logic [7:0] b);
		return b == CH_SP || b == CH_TAB || b == CH_CR;
	endfunction

	function void begin_line();
		line_len = 0;
		name_live = '1;
		name_pos = 0;
		name_begun = 1'b0;
		name_tail = 1'b0;
		val_kind = HK_NONE;
		word_prog = 0;
		ver_state = VER_LEAD;
		val_nonblank = 1'b0;
	endfunction

	function void clear_request();
		req_phase = PH_REQLINE;
		last_three = '0;
		seen_bytes = '0;
		tok_count = 0;
		in_tok = 1'b0;
		pfx_len = 0;
		begin_line();
		{f_bad, f_ws, f_conn, f_key, f_ver, f_proto} = '0;
	endfunction

	function void mark_bad();
		f_bad = 1'b1;
		req_phase = PH_SKIP;
	endfunction

	function void reqline_byte(input logic [7:0] b);
		if (b == CH_LF) begin
			if (tok_count < 3 || pfx_len != 5) begin
				mark_bad();
			end else begin
				req_phase = PH_NAME;
				begin_line();
			end
			return;
		end
		if (is_blank(b) || b == CH_VT || b == CH_FF) begin
			in_tok = 1'b0;
			return;
		end
		if (!in_tok) begin
			in_tok = 1'b1;
			if (tok_count < 4) tok_count++;
		end
		if (tok_count == 3 && pfx_len < 5) begin
			pfx_len = (b == http_pfx[pfx_len]) ? pfx_len + 1 : 6;
		end
	endfunction

	function void name_byte(input logic [7:0] b);
		logic [7:0] c;
		string nm;
		c = to_lower(b);
		if (!name_begun) begin
			if (b == CH_SP || b == CH_TAB) return;
			name_begun = 1'b1;
		end
		if (is_blank(b)) begin
			name_tail = 1'b1;
			return;
		end
		if (name_tail) begin
			name_live = '0;
			return;
		end
		for (int i = 0; i < NUM_HDR; i++) begin
			nm = hdr_name(i);
			if (name_live[i] && !(name_pos < nm.len() && c == nm[name_pos])) begin
				name_live[i] = 1'b0;
			end
		end
		if (name_pos < 31) name_pos++;
	endfunction

	// substring search that restarts on the word's first letter
	function void word_step(input logic [7:0] c, input string w);
		if (word_prog >= w.len()) return;
		if (c == w[word_prog]) word_prog++;
		else if (c == w[0]) word_prog = 1;
		else word_prog = 0;
	endfunction

	function void value_byte(input logic [7:0] b);
		if (!is_blank(b)) val_nonblank = 1'b1;
		case (val_kind)
			HK_UPGRADE: word_step(to_lower(b), ws_word);
			HK_CONNECTION: word_step(to_lower(b), up_word);
			HK_VERSION: begin
				case (ver_state) inside
					VER_LEAD: begin
						if (b == CH_ONE) ver_state = VER_ONE;
						else if (b != CH_SP && b != CH_TAB) ver_state = VER_FAIL;
					end
					VER_ONE: ver_state = (b == CH_THREE) ? VER_THIRTEEN : VER_FAIL;
					VER_THIRTEEN, VER_TRAIL: ver_state = is_blank(b) ? VER_TRAIL : VER_FAIL;
					default: ;
				endcase
			end
			default: ;
		endcase
	endfunction

	function void commit_value();
		case (val_kind)
			HK_UPGRADE: if (word_prog == ws_word.len()) f_ws = 1'b1;
			HK_CONNECTION: if (word_prog == up_word.len()) f_conn = 1'b1;
			HK_KEY: f_key = val_nonblank;
			HK_VERSION: f_ver = (ver_state == VER_THIRTEEN || ver_state == VER_TRAIL);
			HK_PROTOCOL: f_proto = val_nonblank;
			default: ;
		endcase
	endfunction

	function void header_byte(input logic [7:0] b);
		hkind_e kind;
		string nm;
		if (b == CH_LF) begin
			if (req_phase == PH_VALUE) begin
				commit_value();
				req_phase = PH_NAME;
				begin_line();
			end else if (line_len == 0 || (line_len == 1 && last_three[7:0] == CH_CR)) begin
				begin_line();
			end else begin
				mark_bad();
			end
			return;
		end
		if (line_len < 2) line_len++;
		if (req_phase == PH_VALUE) begin
			value_byte(b);
			return;
		end
		if (b == CH_COLON) begin
			kind = HK_NONE;
			for (int i = 0; i < NUM_HDR; i++) begin
				nm = hdr_name(i);
				if (name_live[i] && name_pos == nm.len()) kind = hkind_e'(i + 1);
			end
			req_phase = PH_VALUE;
			val_kind = kind;
			word_prog = 0;
			ver_state = VER_LEAD;
			val_nonblank = 1'b0;
			return;
		end
		name_byte(b);
	endfunction

	// one byte into the parser; returns 1 when the byte produces a word on the output
	function bit parse_request_byte(input logic [7:0] b, input bit eob, output result_t r);
		r = '0;
		if (seen_bytes != COUNT_MAX) seen_bytes++;
		if (last_three == CRLFCR && b == CH_LF) begin
			if (f_bad) r.status = ST_BAD;
			else if (!f_ws || !f_conn || !f_ver) r.status = ST_NOT_UPG;
			else if (!f_key) r.status = ST_NO_KEY;
			else r.status = ST_OK;
			r.consumed_bytes = seen_bytes;
			r.consumed_saturated = (seen_bytes == COUNT_MAX);
			r.protocol_present = f_proto;
			clear_request();
			return 1'b1;
		end
		if (req_phase == PH_REQLINE) reqline_byte(b);
		else if (req_phase != PH_SKIP) header_byte(b);
		last_three = {last_three[15:0], b};
		if (eob) begin
			r.status = ST_NEED_MORE;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic add_byte(input logic [7:0] b);
		msg.insert(msg.size(), b);
	endtask

	task automatic put(input string s);
		for (int i = 0; i < s.len(); i++) add_byte(s[i]);
	endtask

	task automatic put_crlf();
		add_byte(CH_CR);
		add_byte(CH_LF);
	endtask

	task automatic put_sep();
		case ($urandom_range(0, 9))
			6: add_byte(CH_TAB);
			7: add_byte(CH_VT);
			8: add_byte(CH_FF);
			9: add_byte(CH_CR);
			default: add_byte(CH_SP);
		endcase
		if ($urandom_range(0, 7) == 0) add_byte(CH_SP);
	endtask

	task automatic put_eol(input bit force_crlf);
		if (force_crlf || $urandom_range(0, 2) != 0) put_crlf();
		else add_byte(CH_LF);
	endtask

	function string mixed_case(input string s);
		string r;
		logic [7:0] ch;
		r = s;
		for (int i = 0; i < r.len(); i++) begin
			ch = r[i];
			if (((ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z")) && $urandom_range(0, 1)) begin
				r.putc(i, ch ^ 8'h20);
			end
		end
		return r;
	endfunction

	task automatic put_line(input line_e k, input bit last);
		string nm;
		string val;
		logic [7:0] b;
		if (k == LN_BLANK) begin
			// empty line then a line holding only CR, both skipped
			add_byte(CH_LF);
			put_crlf();
			return;
		end
		if (k == LN_NO_COLON) begin
			put(mixed_case("broken header"));
			repeat ($urandom_range(0, 6)) begin
				if ($urandom_range(0, 3) == 0) add_byte(8'($urandom_range(128, 255)));
				else add_byte(8'($urandom_range(97, 122)));
			end
			put_eol(last);
			return;
		end
		case (k)
			LN_UPGRADE: nm = "Upgrade";
			LN_CONNECTION: nm = "Connection";
			LN_KEY: nm = "Sec-WebSocket-Key";
			LN_VERSION: nm = "Sec-WebSocket-Version";
			LN_PROTOCOL: nm = "Sec-WebSocket-Protocol";
			default: begin
				case ($urandom_range(0, 3))
					0: nm = "Host";
					1: nm = "Origin";
					2: nm = "X-Mode";
					default: nm = "Upgrade-Insecure-Requests";
				endcase
			end
		endcase
		case ($urandom_range(0, 19))
			0: nm = {nm, "s"};
			1: nm = nm.substr(0, nm.len() - 2);
			2: nm = {nm.substr(0, 1), " ", nm.substr(2, nm.len() - 1)};
			default: ;
		endcase
		case ($urandom_range(0, 9))
			0: put(" ");
			1: put("\t");
			default: ;
		endcase
		put(mixed_case(nm));
		if ($urandom_range(0, 6) == 0) put(" \t");
		put(":");
		if ($urandom_range(0, 9) < 7) put(" ");
		val = "";
		case (k)
			LN_UPGRADE: begin
				case ($urandom_range(0, 5)) inside
					0, 1: val = "websocket";
					2: val = "h2c, WebSocket ";
					3: val = "wwebsocket";
					4: val = "websockt";
					default: ;
				endcase
			end
			LN_CONNECTION: begin
				case ($urandom_range(0, 5)) inside
					0, 1: val = "Upgrade";
					2: val = "keep-alive, upgrade";
					3: val = "uupgrade";
					4: val = "upgrad";
					default: val = "keep-alive";
				endcase
			end
			LN_KEY: begin
				case ($urandom_range(0, 5)) inside
					0, 1, 2: val = "dGhlIHNhbXBsZSBub25jZQ==";
					3: val = "";
					4: val = " \t";
					default: val = "x";
				endcase
			end
			LN_VERSION: begin
				case ($urandom_range(0, 9)) inside
					0, 1, 2: val = "13";
					3: val = "13 \t";
					4: val = "\t13";
					5: val = "1";
					6: val = "133";
					7: val = "14";
					8: val = "";
					default: val = "1 3";
				endcase
			end
			LN_PROTOCOL: begin
				case ($urandom_range(0, 4)) inside
					0, 1: val = "chat";
					2: val = "";
					3: val = " \t ";
					default: val = "chat, superchat";
				endcase
			end
			default: ;
		endcase
		put(mixed_case(val));
		if (k == LN_OTHER) begin
			repeat ($urandom_range(0, 10)) begin
				b = 8'($urandom_range(1, 255));
				if (b == CH_LF || b == CH_CR) b = "z";
				add_byte(b);
			end
		end
		put_eol(last);
	endtask

	task automatic build_request();
		line_e lines[$];
		line_e t;
		int j;
		msg.delete();
		if ($urandom_range(0, 9) < 8) lines.insert(lines.size(), LN_UPGRADE);
		if ($urandom_range(0, 9) < 8) lines.insert(lines.size(), LN_CONNECTION);
		if ($urandom_range(0, 9) < 8) lines.insert(lines.size(), LN_KEY);
		if ($urandom_range(0, 9) < 8) lines.insert(lines.size(), LN_VERSION);
		if ($urandom_range(0, 1)) lines.insert(lines.size(), LN_PROTOCOL);
		repeat ($urandom_range(0, 2)) lines.insert(lines.size(), LN_OTHER);
		if ($urandom_range(0, 11) == 0) lines.insert(lines.size(), LN_NO_COLON);
		if ($urandom_range(0, 11) == 0) lines.insert(lines.size(), LN_BLANK);
		if ($urandom_range(0, 7) == 0) lines.insert(lines.size(), line_e'($urandom_range(0, 4)));
		for (int i = lines.size() - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = lines[i];
			lines[i] = lines[j];
			lines[j] = t;
		end
		if ($urandom_range(0, 4) == 0) put_sep();
		case ($urandom_range(0, 5))
			4: put("post");
			5: begin
				add_byte(8'hC7);
				put("ET");
			end
			default: put("GET");
		endcase
		put_sep();
		if ($urandom_range(0, 9) != 0) begin
			put("/chat");
			put_sep();
		end
		case ($urandom_range(0, 9))
			7: put("http/1.1");
			8: put("HTTP1.1");
			9: put("HTT");
			default: put("HTTP/1.1");
		endcase
		if ($urandom_range(0, 9) == 0) begin
			put_sep();
			put("extra");
		end
		put_eol(lines.size() == 0);
		foreach (lines[i]) put_line(lines[i], i == lines.size() - 1);
		put_crlf();
	endtask

	task automatic make_noise();
		msg.delete();
		repeat ($urandom_range(4, 40)) begin
			case ($urandom_range(0, 7))
				0: add_byte(CH_CR);
				1: add_byte(CH_LF);
				2: add_byte(CH_COLON);
				3: add_byte(CH_SP);
				default: add_byte(8'($urandom_range(0, 255)));
			endcase
		end
	endtask

	task automatic offer_byte(input logic [7:0] b, input bit eob);
		if (!calm) begin
			while ($urandom_range(0, 99) < IDLE_PCT) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		data_byte <= b;
		end_of_buffer <= eob;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic feed(input logic [7:0] b, input bit eob);
		result_t r;
		if (parse_request_byte(b, eob, r)) begin
			expected_results.insert(expected_results.size(), r);
		end
		offer_byte(b, eob);
		bytes_sent++;
	endtask

	task automatic send_msg();
		foreach (msg[i]) begin
			feed(msg[i], ($urandom_range(0, 99) < 3) ||
				(i == msg.size() - 1 && $urandom_range(0, 3) == 0));
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin : result_check
		result_t want;
		if (out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: expected no word, actual status %0d consumed %0d sat %0b proto %0b",
					$time, status, consumed_bytes, consumed_saturated, protocol_present);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				if (status !== want.status || consumed_bytes !== want.consumed_bytes ||
						consumed_saturated !== want.consumed_saturated ||
						protocol_present !== want.protocol_present) begin
					$display("%0t: expected status %0d consumed %0d sat %0b proto %0b",
						$time, want.status, want.consumed_bytes,
						want.consumed_saturated, want.protocol_present);
					$display("%0t:   actual status %0d consumed %0d sat %0b proto %0b",
						$time, status, consumed_bytes, consumed_saturated,
						protocol_present);
					mismatches++;
				end
			end
		end
		out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
			$display("tb_websocket_upgrade_request_parser: FAIL");
			$finish;
		end
	end

	initial begin
		drive_row_t row;
		result_t r;
		bit gives;
		int sel;
		clear_request();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_LEN; i++) begin
			row = DIRECTED_ROWS[i];
			gives = parse_request_byte(row.ch, row.eob, r);
			if (row.typed) begin
				gives = row.gives;
				r = row.res;
			end
			if (gives) expected_results.insert(expected_results.size(), r);
			offer_byte(row.ch, row.eob);
		end

		// mostly well formed requests, some cut short, some raw noise
		while (bytes_sent < 2000) begin
			calm = (bytes_sent >= 700 && bytes_sent < 1100);
			sel = $urandom_range(0, 99);
			if (sel < 90) begin
				build_request();
				if (sel >= 80) msg = msg[0:$urandom_range(0, msg.size() - 1)];
			end else begin
				make_noise();
			end
			send_msg();
		end
		calm = 1'b0;

		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb_websocket_upgrade_request_parser: PASS");
		end else begin
			$display("tb_websocket_upgrade_request_parser: FAIL");
		end
		$finish;
	end

endmodule
